FILE: hdl/dqrv_pkg.sv
// ----------------------------------------------------------------------------
// dqrv_pkg
// Shared types and constants for the deque with remove-by-value unit.
// ----------------------------------------------------------------------------
package dqrv_pkg;

  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PREPEND    = 3'd0,
    CMD_APPEND     = 3'd1,
    CMD_REMOVE     = 3'd2,
    CMD_TAKE_FRONT = 3'd3,
    CMD_TAKE_BACK  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_MISS    = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_READ,
    S_SEARCH,
    S_SHIFT,
    S_DONE
  } state_e;

  typedef struct packed {
    status_e            status;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage

FILE: hdl/deque_with_remove_by_value_unit.sv
// ----------------------------------------------------------------------------
// deque_with_remove_by_value_unit
// Bounded deque of nonzero words with prepend, append, remove-by-value and
// front/back take.
//
// Input channel (in_valid_i / in_stall_o) carries cmd_i and value_i; output
// channel (out_valid_o / out_stall_i) carries status_o, value_out_o and
// count_o, one result item for every input item, in order.
// One item is worked at a time; in_stall_o stays high from the cycle after
// acceptance until the sequencer returns to idle.
// Path from acceptance to out_valid_o: inserts, null values, full and empty
// cases go from decide straight to done; front or back takes pass through
// one registered slot read; remove walks the deque, reading one slot per
// cycle through the single read port and closing the gap one slot per cycle.
// No new item is accepted until the current one has left the sequencer.
// The result sits in an output register; while the receiver stalls, the
// next item is still accepted and worked, and it waits in the sequencer
// until that register is taken.
// Reset empties the deque (count zero, head at slot zero) and drops any
// pending result; slot contents are not cleared.
// ----------------------------------------------------------------------------
module deque_with_remove_by_value_unit import dqrv_pkg::*; #(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [CMD_W-1:0]   cmd_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [VALUE_W-1:0] value_out_o,
  output logic [COUNT_W-1:0] count_o
);

  localparam int unsigned PTR_W = $clog2(CAPACITY);

  logic                  res_valid;
  logic                  res_ready;
  result_t               res;
  logic                  mem_we;
  logic [PTR_W-1:0]      mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [PTR_W-1:0]      mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  logic    out_valid_q, out_valid_d;
  result_t out_q;

  dqrv_seq #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .value_i     (value_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  dqrv_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // load when the output register is empty or being taken
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ready) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign value_out_o = out_q.value;
  assign count_o     = out_q.count;

endmodule

FILE: hdl/dqrv_ram.sv
// ----------------------------------------------------------------------------
// dqrv_ram
// Slot storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dqrv_ram import dqrv_pkg::*; #(
  parameter int unsigned DEPTH = CAPACITY_DEF,
  parameter int unsigned WIDTH = DATA_WIDTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/dqrv_seq.sv
// ----------------------------------------------------------------------------
// dqrv_seq
// Command sequencer with a shared slot-address adder and value comparator.
// ----------------------------------------------------------------------------
module dqrv_seq import dqrv_pkg::*; #(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int unsigned PTR_W = $clog2(CAPACITY)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CMD_W-1:0]      cmd_i,
  input  logic [VALUE_W-1:0]    value_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output result_t               res_o,
  output logic                  mem_we_o,
  output logic [PTR_W-1:0]      mem_waddr_o,
  output logic [DATA_WIDTH-1:0] mem_wdata_o,
  output logic                  mem_re_o,
  output logic [PTR_W-1:0]      mem_raddr_o,
  input  logic [DATA_WIDTH-1:0] mem_rdata_i
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  state_e                state_q, state_d;
  logic [PTR_W-1:0]      head_q, head_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CMD_W-1:0]      cmd_q, cmd_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [PTR_W-1:0]      pos_q, pos_d;
  logic [PTR_W-1:0]      hole_q, hole_d;
  logic [PTR_W-1:0]      raddr_q, raddr_d;
  logic [DATA_WIDTH-1:0] taken_q, taken_d;
  status_e               status_q, status_d;

  logic [CNT_W-1:0] off;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_wrap;
  logic [PTR_W-1:0] slot;
  logic [CNT_W-1:0] pos_next;
  logic             is_insert;
  logic             is_remove;
  logic             bad;
  logic             full;
  logic             empty;
  logic             hit;
  logic             last;

  assign is_insert = (cmd_q == CMD_PREPEND) || (cmd_q == CMD_APPEND);
  assign is_remove = (cmd_q == CMD_REMOVE);
  assign bad       = (cmd_q > CMD_TAKE_BACK) ||
                     ((is_insert || is_remove) && (val_q == '0));
  assign full      = (count_q == CNT_W'(CAPACITY));
  assign empty     = (count_q == '0);
  assign hit       = (mem_rdata_i == val_q);
  assign pos_next  = CNT_W'(pos_q) + CNT_W'(1);
  assign last      = (pos_next >= count_q);

  // shared slot-address unit: (head + off) mod CAPACITY
  always_comb begin
    off = '0;
    unique case (state_q)
      S_DECIDE: begin
        unique case (cmd_q)
          CMD_PREPEND:   off = CNT_W'(CAPACITY - 1);
          CMD_APPEND:    off = count_q;
          CMD_TAKE_BACK: off = count_q - CNT_W'(1);
          default:       off = '0;
        endcase
      end
      S_READ:   off = CNT_W'(1);
      S_SEARCH,
      S_SHIFT:  off = pos_next;
      default:  off = '0;
    endcase
  end

  assign sum      = SUM_W'(head_q) + SUM_W'(off);
  assign sum_wrap = sum - SUM_W'(CAPACITY);
  assign slot     = (sum >= SUM_W'(CAPACITY)) ? PTR_W'(sum_wrap) : PTR_W'(sum);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (bad || is_insert) begin
          state_d = S_DONE;
        end else if (empty) begin
          state_d = S_DONE;
        end else if (is_remove) begin
          state_d = S_SEARCH;
        end else begin
          state_d = S_READ;
        end
      end
      S_READ: state_d = S_DONE;
      S_SEARCH: begin
        if (last) begin
          state_d = S_DONE;
        end else if (hit) begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    cmd_d       = cmd_q;
    val_d       = val_q;
    pos_d       = pos_q;
    hole_d      = hole_q;
    taken_d     = taken_q;
    status_d    = status_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = slot;
    mem_wdata_o = val_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = slot;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d = cmd_i;
          val_d = DATA_WIDTH'(value_i);
        end
      end
      S_DECIDE: begin
        taken_d  = '0;
        status_d = ST_OK;
        pos_d    = '0;
        if (bad) begin
          status_d = ST_INVALID;
        end else if (is_insert) begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            mem_we_o = 1'b1;
            count_d  = count_q + CNT_W'(1);
            if (cmd_q == CMD_PREPEND) begin
              head_d = slot;
            end
          end
        end else if (empty) begin
          status_d = ST_MISS;
        end else begin
          mem_re_o = 1'b1;
        end
      end
      S_READ: begin
        taken_d = mem_rdata_i;
        count_d = count_q - CNT_W'(1);
        if (cmd_q == CMD_TAKE_FRONT) begin
          head_d = slot;
        end
      end
      S_SEARCH: begin
        if (hit) begin
          hole_d = raddr_q;
        end
        if (last) begin
          if (hit) begin
            count_d = count_q - CNT_W'(1);
          end else begin
            status_d = ST_MISS;
          end
        end else begin
          mem_re_o = 1'b1;
          pos_d    = PTR_W'(pos_next);
        end
      end
      S_SHIFT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = hole_q;
        mem_wdata_o = mem_rdata_i;
        hole_d      = raddr_q;
        if (last) begin
          count_d = count_q - CNT_W'(1);
        end else begin
          mem_re_o = 1'b1;
          pos_d    = PTR_W'(pos_next);
        end
      end
      default: begin
      end
    endcase
  end

  assign raddr_d = mem_re_o ? mem_raddr_o : raddr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    val_q    <= val_d;
    pos_q    <= pos_d;
    hole_q   <= hole_d;
    raddr_q  <= raddr_d;
    taken_q  <= taken_d;
    status_q <= status_d;
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign res_valid_o  = (state_q == S_DONE);
  assign res_o.status = status_q;
  assign res_o.value  = VALUE_W'(taken_q);
  assign res_o.count  = COUNT_W'(count_q);

endmodule
